### rtl/grayscale_window_lut_render_assert.svh
// Assertion macros shared by the grayscale window renderer.
// Used by the top level only; no other dependencies.
`ifndef GRAYSCALE_WINDOW_LUT_RENDER_ASSERT_SVH
`define GRAYSCALE_WINDOW_LUT_RENDER_ASSERT_SVH

// Checks that an implication holds on every edge outside reset.
`define GWLR_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define GWLR_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

### rtl/gwlr_pkg.sv
// Shared types and constants of the grayscale window renderer.
// No dependencies.
package gwlr_pkg;
   localparam int SAMPLE_BITS_DEFAULT = 32;
   localparam int REG_BITS = 32;
   localparam int IDX_BITS = 8;
   localparam int LEVEL_BITS = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int QUOT_BITS = 8;
   localparam int DIFF_BITS = REG_BITS + 2;

   localparam logic [2:0] CSR_WINDOW_LOW = 3'd0;
   localparam logic [2:0] CSR_WINDOW_HIGH = 3'd1;
   localparam logic [2:0] CSR_LAYER_ALPHA = 3'd2;
   localparam logic [2:0] CSR_NODATA_ENABLE = 3'd3;
   localparam logic [2:0] CSR_NODATA_VALUE = 3'd4;

   localparam logic OP_MAP = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Entry of the queue between front and back.
   typedef struct packed {
      logic                  op;
      logic [IDX_BITS-1:0]   table_index;
      logic [LEVEL_BITS-1:0] table_value;
      logic                  last;
      logic [LEVEL_BITS-1:0] alpha;
      logic                  force_zero;
      logic                  force_top;
      logic [DIFF_BITS-1:0]  diff;
      logic [DIFF_BITS-1:0]  range;
   } item_type;
endpackage

### rtl/grayscale_window_lut_render.sv
// Top level of the window/level grayscale renderer: CSRs, front, queue, back.
// Depends on gwlr_pkg, gwlr_front, gwlr_queue, gwlr_back and the assert header.
//
// Usage: push items on req_* while full is low; a map item (op 0) yields one
// result on rsp_*, a table write (op 1) yields none.
// The block takes one item per cycle while full is low. Empty falls once a map
// item has passed the front register, the queue, the divider input register, eight
// divider stages that each settle one quotient bit of 256*(v-low)/(high-low), the
// table read register and the result queue. The table write lands at the end
// of the divider, so later reads see it in order.
// Results wait in a result queue; when the receiver stops popping, credits run
// out and full rises, with nothing lost. Reset empties every queue, restores
// the register defaults, and the gray table reads as the identity ramp until
// an entry is written. CSR writes are always accepted (csr_ready is high) and
// must be made only while the block is idle.
`include "grayscale_window_lut_render_assert.svh"
module grayscale_window_lut_render #(
   parameter int SAMPLE_BITS = gwlr_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_op,
   input  logic [31:0] req_sample,
   input  logic [7:0]  req_table_index,
   input  logic [7:0]  req_table_value,
   input  logic        req_last_pixel,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_gray,
   output logic [7:0]  rsp_alpha_out,
   output logic        rsp_last_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   logic signed [31:0] window_low_ff, window_high_ff, nodata_value_ff;
   logic [7:0]         layer_alpha_ff;
   logic               nodata_enable_ff;
   logic               f_ready, f_valid, q_ready, q_valid, b_ready;
   gwlr_pkg::item_type f_item, q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff <= '0;
         window_high_ff <= 32'sd255;
         layer_alpha_ff <= 8'd255;
         nodata_enable_ff <= 1'b0;
         nodata_value_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            gwlr_pkg::CSR_WINDOW_LOW: window_low_ff <= csr_data;
            gwlr_pkg::CSR_WINDOW_HIGH: window_high_ff <= csr_data;
            gwlr_pkg::CSR_LAYER_ALPHA: layer_alpha_ff <= csr_data[7:0];
            gwlr_pkg::CSR_NODATA_ENABLE: nodata_enable_ff <= csr_data[0];
            gwlr_pkg::CSR_NODATA_VALUE: nodata_value_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign full = !f_ready;

   gwlr_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(push), .in_ready(f_ready),
      .op(req_op), .sample(req_sample), .table_index(req_table_index),
      .table_value(req_table_value), .last_pixel(req_last_pixel),
      .window_low(window_low_ff), .window_high(window_high_ff),
      .layer_alpha(layer_alpha_ff), .nodata_enable(nodata_enable_ff),
      .nodata_value(nodata_value_ff),
      .out_valid(f_valid), .out_ready(q_ready), .out_item(f_item)
   );

   gwlr_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(q_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(b_ready), .out_item(q_item)
   );

   gwlr_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(b_ready), .in_item(q_item),
      .empty(empty), .pop(pop),
      .gray(rsp_gray), .alpha_out(rsp_alpha_out), .last_out(rsp_last_out)
   );

   `GWLR_ASSERT_NEXT(a_alpha_reg, clock, reset, csr_valid && csr_index == gwlr_pkg::CSR_LAYER_ALPHA, layer_alpha_ff == $past(csr_data[7:0]), "layer alpha write lost")
   `GWLR_ASSERT_IMPL(a_nodata_alpha, clock, reset, f_valid && !nodata_enable_ff, f_item.alpha == layer_alpha_ff || f_item.op == gwlr_pkg::OP_WRITE, "alpha classify")
   `GWLR_ASSERT_IMPL(a_zero_top, clock, reset, f_valid, !(f_item.force_zero && f_item.force_top), "window cases overlap")
endmodule

### rtl/gwlr_front.sv
// Front end: takes items, computes offset and range, classifies window cases.
// Depends on gwlr_pkg.
module gwlr_front #(
   parameter int SAMPLE_BITS = gwlr_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic                                  op,
   input  logic [31:0]                           sample,
   input  logic [gwlr_pkg::IDX_BITS-1:0]         table_index,
   input  logic [gwlr_pkg::LEVEL_BITS-1:0]       table_value,
   input  logic                                  last_pixel,
   input  logic signed [gwlr_pkg::REG_BITS-1:0]  window_low,
   input  logic signed [gwlr_pkg::REG_BITS-1:0]  window_high,
   input  logic [gwlr_pkg::LEVEL_BITS-1:0]       layer_alpha,
   input  logic                                  nodata_enable,
   input  logic signed [gwlr_pkg::REG_BITS-1:0]  nodata_value,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output gwlr_pkg::item_type                    out_item
);
   localparam int DB = gwlr_pkg::DIFF_BITS;
   logic                   valid_ff, valid_in;
   gwlr_pkg::item_type     item_ff, item_in;
   logic signed [31:0]     v_ext;
   logic signed [DB-1:0]   d, r;

   assign v_ext = 32'(signed'(sample[SAMPLE_BITS-1:0]));
   assign d = DB'(v_ext) - DB'(window_low);
   assign r = DB'(window_high) - DB'(window_low);

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      item_in.op = op;
      item_in.table_index = table_index;
      item_in.table_value = table_value;
      item_in.last = last_pixel;
      item_in.alpha = (nodata_enable && v_ext == nodata_value) ? '0 : layer_alpha;
      item_in.force_zero = d <= 0;
      item_in.force_top = (r <= 0 || d >= r) && d > 0;
      item_in.diff = d;
      item_in.range = r;
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;
endmodule

### rtl/gwlr_queue.sv
// Two-entry queue decoupling the front end from the back end.
// Depends on gwlr_pkg.
module gwlr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  gwlr_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output gwlr_pkg::item_type out_item
);
   gwlr_pkg::item_type mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_item = mem_ff[rptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wptr_ff] <= in_item;
      end
   end
endmodule

### rtl/gwlr_back.sv
// Back end: pipelined restoring divider, gray table, and result queue.
// Depends on gwlr_pkg.
module gwlr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  gwlr_pkg::item_type              in_item,
   output logic                            empty,
   input  logic                            pop,
   output logic [gwlr_pkg::LEVEL_BITS-1:0] gray,
   output logic [gwlr_pkg::LEVEL_BITS-1:0] alpha_out,
   output logic                            last_out
);
   localparam int QB = gwlr_pkg::QUOT_BITS;
   localparam int DB = gwlr_pkg::DIFF_BITS;
   localparam int STAGES = QB;
   localparam int LB = gwlr_pkg::LEVEL_BITS;
   localparam int DEPTH = gwlr_pkg::TABLE_DEPTH;
   localparam int OQ = STAGES + 4;
   localparam int OQB = $clog2(OQ + 1);
   localparam int OPB = $clog2(OQ);

   // Per-stage divider state: remainder, quotient bits and the item.
   gwlr_pkg::item_type    st_item_ff [STAGES+1];
   logic                  st_valid_ff [STAGES+1];
   logic [DB-1:0]         st_rem_ff [STAGES+1];
   logic [QB-1:0]         st_q_ff [STAGES+1];

   // Result queue holds everything in flight, so a credit count gates entry.
   logic [OQB-1:0]        credit_ff, credit_in;
   logic [LB-1:0]         table_mem [DEPTH];
   logic [DEPTH-1:0]      written_ff;
   logic [LB-1:0]         rd_ff;
   logic [gwlr_pkg::IDX_BITS-1:0] rd_idx_ff;
   logic                  rd_wr_ff;
   logic                  rd_valid_ff;
   logic [LB-1:0]         rd_alpha_ff;
   logic                  rd_last_ff;
   logic [QB-1:0]         qf;
   logic [gwlr_pkg::IDX_BITS-1:0] idx;
   gwlr_pkg::item_type    tail;

   typedef struct packed {
      logic [LB-1:0] gray;
      logic [LB-1:0] alpha;
      logic          last;
   } res_type;
   res_type               oq_ff [OQ];
   logic [OPB-1:0]        ow_ff, or_ff;
   logic [OQB-1:0]        ocount_ff;
   logic                  opush, opop, take, deliver;

   assign in_ready = credit_ff != '0;
   assign take = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STAGES; s++) begin
            st_valid_ff[s] <= 1'b0;
         end
      end else begin
         st_valid_ff[0] <= take;
         for (int s = 1; s <= STAGES; s++) begin
            st_valid_ff[s] <= st_valid_ff[s-1];
         end
      end
      st_item_ff[0] <= in_item;
      st_rem_ff[0] <= in_item.diff;
      st_q_ff[0] <= '0;
      for (int s = 1; s <= STAGES; s++) begin
         // One quotient bit of diff*256/range per stage, most significant first:
         // the remainder doubles and the range comes off where it fits.
         logic [DB-1:0] trial;
         trial = {st_rem_ff[s-1][DB-2:0], 1'b0};
         st_item_ff[s] <= st_item_ff[s-1];
         if (trial >= st_item_ff[s-1].range) begin
            st_rem_ff[s] <= trial - st_item_ff[s-1].range;
            st_q_ff[s] <= st_q_ff[s-1] | QB'(1 << (QB - s));
         end else begin
            st_rem_ff[s] <= trial;
            st_q_ff[s] <= st_q_ff[s-1];
         end
      end
   end

   // The clamped window cases override the quotient.
   assign tail = st_item_ff[STAGES];
   assign qf = st_q_ff[STAGES];
   always_comb begin
      if (tail.force_zero) begin
         idx = '0;
      end else if (tail.force_top) begin
         idx = '1;
      end else begin
         idx = qf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= st_valid_ff[STAGES] && tail.op == gwlr_pkg::OP_MAP;
         if (st_valid_ff[STAGES] && tail.op == gwlr_pkg::OP_WRITE) begin
            written_ff[tail.table_index] <= 1'b1;
         end
      end
      if (st_valid_ff[STAGES] && tail.op == gwlr_pkg::OP_WRITE) begin
         table_mem[tail.table_index] <= tail.table_value;
      end
      rd_ff <= table_mem[idx];
      rd_idx_ff <= idx;
      rd_wr_ff <= written_ff[idx];
      rd_alpha_ff <= tail.alpha;
      rd_last_ff <= tail.last;
   end

   assign opush = rd_valid_ff;
   assign opop = ocount_ff != '0 && pop;
   assign deliver = st_valid_ff[STAGES] && tail.op == gwlr_pkg::OP_WRITE;

   always_comb begin
      credit_in = credit_ff - OQB'(take) + OQB'(opop) + OQB'(deliver);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= OQB'(OQ);
         ow_ff <= '0;
         or_ff <= '0;
         ocount_ff <= '0;
      end else begin
         credit_ff <= credit_in;
         ocount_ff <= ocount_ff + OQB'(opush) - OQB'(opop);
         if (opush) begin
            ow_ff <= (ow_ff == OPB'(OQ - 1)) ? '0 : ow_ff + OPB'(1);
         end
         if (opop) begin
            or_ff <= (or_ff == OPB'(OQ - 1)) ? '0 : or_ff + OPB'(1);
         end
      end
      if (opush) begin
         oq_ff[ow_ff].gray <= rd_wr_ff ? rd_ff : rd_idx_ff;
         oq_ff[ow_ff].alpha <= rd_alpha_ff;
         oq_ff[ow_ff].last <= rd_last_ff;
      end
   end

   assign empty = ocount_ff == '0;
   assign gray = oq_ff[or_ff].gray;
   assign alpha_out = oq_ff[or_ff].alpha;
   assign last_out = oq_ff[or_ff].last;
endmodule

### dv/gray_render_checker.sv
// Checker for the grayscale window renderer: watches the input, result and CSR
// channels, predicts each pixel and compares it. Depends on gwlr_pkg.
module gray_render_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic        req_op,
   input  logic [31:0] req_sample,
   input  logic [7:0]  req_table_index,
   input  logic [7:0]  req_table_value,
   input  logic        req_last_pixel,
   input  logic        empty,
   input  logic        pop,
   input  logic [7:0]  rsp_gray,
   input  logic [7:0]  rsp_alpha_out,
   input  logic        rsp_last_out,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          errors,
   output int          pending,
   output int          pixels_checked
);
   typedef struct {
      logic [7:0] gray;
      logic [7:0] alpha;
      logic       last;
   } pixel_t;

   pixel_t     expected_pixels[$];
   longint     win_low, win_high, nodata_val;
   logic [7:0] alpha_reg;
   logic       nodata_en;
   logic [7:0] gray_lut[256];

   task automatic report(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic logic [7:0] window_slot(input longint v);
      longint d, span, q;
      d = v - win_low;
      span = win_high - win_low;
      if (span <= 0) return (d <= 0) ? 8'd0 : 8'd255;
      if (d <= 0) return 8'd0;
      if (d >= span) return 8'd255;
      q = (d * 256) / span;
      if (q > 255) q = 255;
      return q[7:0];
   endfunction

   function automatic pixel_t predict_pixel(input logic [31:0] raw, input logic last);
      pixel_t p;
      longint v;
      v = longint'($signed(raw));
      p.gray = gray_lut[window_slot(v)];
      p.alpha = (nodata_en && v == nodata_val) ? 8'd0 : alpha_reg;
      p.last = last;
      return p;
   endfunction

   initial begin
      errors = 0;
      pixels_checked = 0;
   end

   assign pending = expected_pixels.size();

   always @(posedge clock) begin
      pixel_t want;
      if (reset) begin
         expected_pixels.delete();
         win_low = 0;
         win_high = 255;
         alpha_reg = 8'd255;
         nodata_en = 1'b0;
         nodata_val = 0;
         for (int i = 0; i < 256; i++) gray_lut[i] = i[7:0];
      end else begin
         if (pop && !empty) begin
            if (expected_pixels.size() == 0) begin
               report("unexpected result transfer", rsp_gray, -1);
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked++;
               if (rsp_gray !== want.gray) report("gray", rsp_gray, want.gray);
               if (rsp_alpha_out !== want.alpha) report("alpha", rsp_alpha_out, want.alpha);
               if (rsp_last_out !== want.last) report("last", rsp_last_out, want.last);
            end
         end
         if (push && !full) begin
            if (req_op == gwlr_pkg::OP_WRITE) gray_lut[req_table_index] = req_table_value;
            else expected_pixels.push_back(predict_pixel(req_sample, req_last_pixel));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gwlr_pkg::CSR_WINDOW_LOW: win_low = longint'($signed(csr_data));
               gwlr_pkg::CSR_WINDOW_HIGH: win_high = longint'($signed(csr_data));
               gwlr_pkg::CSR_LAYER_ALPHA: alpha_reg = csr_data[7:0];
               gwlr_pkg::CSR_NODATA_ENABLE: nodata_en = csr_data[0];
               gwlr_pkg::CSR_NODATA_VALUE: nodata_val = longint'($signed(csr_data));
               default: ;
            endcase
         end
      end
   end
endmodule

### dv/testbench.sv
// Top of the grayscale window renderer test: clock, reset, stimulus and verdict.
// Depends on gwlr_pkg, the renderer RTL and gray_render_checker.
module testbench;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_op = gwlr_pkg::OP_MAP;
   logic [31:0] req_sample = '0;
   logic [7:0]  req_table_index = '0;
   logic [7:0]  req_table_value = '0;
   logic        req_last_pixel = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_gray;
   logic [7:0]  rsp_alpha_out;
   logic        rsp_last_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = gwlr_pkg::CSR_WINDOW_LOW;
   logic [31:0] csr_data = '0;
   int          errors, pending, pixels_checked;
   int          send_idle = 0, recv_stall = 0;
   int          writes_sent = 0;
   logic [31:0] cur_low = 0, cur_high = 255, cur_nodata = 0;

   grayscale_window_lut_render dut (.*);

   gray_render_checker checker_i (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #3_000_000;
      $display("timeout waiting for results");
      $display("DONE: errors detected");
      $finish;
   end

   always @(negedge clock) pop <= ($urandom_range(99) >= recv_stall);

   task automatic send(input logic op, input logic [31:0] s, input logic [7:0] ti,
                       input logic [7:0] tv, input logic last);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_op <= op;
      req_sample <= s;
      req_table_index <= ti;
      req_table_value <= tv;
      req_last_pixel <= last;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      if (op == gwlr_pkg::OP_WRITE) writes_sent++;
   endtask

   task automatic pixel(input logic [31:0] s, input logic last = 1'b0);
      send(gwlr_pkg::OP_MAP, s, 8'($urandom), 8'($urandom), last);
   endtask

   // Registers change only once the pipeline has drained, including table writes
   // that produce no result.
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
      if (idx == gwlr_pkg::CSR_WINDOW_LOW) cur_low = val;
      if (idx == gwlr_pkg::CSR_WINDOW_HIGH) cur_high = val;
      if (idx == gwlr_pkg::CSR_NODATA_VALUE) cur_nodata = val;
   endtask

   function automatic logic [31:0] pick_sample();
      int unsigned r;
      longint span;
      r = $urandom_range(99);
      span = longint'($signed(cur_high)) - longint'($signed(cur_low));
      if (r < 45 && span > 0)
         return 32'(longint'($signed(cur_low)) + longint'($urandom) % (span + 1));
      if (r < 55) return cur_low + 32'($urandom_range(4)) - 32'd2;
      if (r < 65) return cur_high + 32'($urandom_range(4)) - 32'd2;
      if (r < 72) return cur_nodata;
      if (r < 76) return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      return $urandom;
   endfunction

   task automatic random_window();
      int unsigned mode;
      logic [31:0] lo, hi;
      mode = $urandom_range(5);
      lo = $urandom;
      case (mode)
         0: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
         1: hi = lo + 32'($urandom_range(600, 1));
         2: hi = lo;
         3: begin lo = $urandom_range(1000, 0); hi = lo - 32'($urandom_range(50, 1)); end
         4: begin lo = -32'sd300; hi = 32'($urandom_range(70000, 1)); end
         default: hi = $urandom;
      endcase
      write_csr(gwlr_pkg::CSR_WINDOW_LOW, lo);
      write_csr(gwlr_pkg::CSR_WINDOW_HIGH, hi);
      write_csr(gwlr_pkg::CSR_LAYER_ALPHA, $urandom_range(3) == 0 ? 32'd0 : $urandom);
      write_csr(gwlr_pkg::CSR_NODATA_ENABLE, $urandom);
      write_csr(gwlr_pkg::CSR_NODATA_VALUE,
                $urandom_range(1) ? lo + 32'($urandom_range(3)) : $urandom);
   endtask

   initial begin
      int idle_send[4];
      int idle_recv[4];
      idle_send = '{0, 56, 0, 25};
      idle_recv = '{0, 0, 56, 25};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default window 0..255 over the identity table, edges and clamping, then table writes.
      pixel(32'd0);
      pixel(32'd1);
      pixel(32'd128);
      pixel(32'd254);
      pixel(32'd255);
      pixel(32'd256);
      pixel(32'hffff_ffff);
      pixel(32'h7fff_ffff, 1'b1);
      pixel(32'h8000_0000);
      send(gwlr_pkg::OP_WRITE, $urandom, 8'd0, 8'd255, 1'b1);
      send(gwlr_pkg::OP_WRITE, $urandom, 8'd255, 8'd0, 1'b0);
      send(gwlr_pkg::OP_WRITE, $urandom, 8'd128, 8'haa, 1'b1);
      pixel(32'h8000_0000);
      pixel(32'd300, 1'b1);
      pixel(32'd128);
      // No-data on the minimum value, then an inverted and an empty window.
      write_csr(gwlr_pkg::CSR_NODATA_VALUE, 32'h8000_0000);
      write_csr(gwlr_pkg::CSR_NODATA_ENABLE, 32'd1);
      write_csr(gwlr_pkg::CSR_LAYER_ALPHA, 32'd0);
      write_csr(gwlr_pkg::CSR_LAYER_ALPHA, 32'd200);
      pixel(32'h8000_0000);
      pixel(32'h8000_0001);
      write_csr(gwlr_pkg::CSR_WINDOW_LOW, 32'd10);
      write_csr(gwlr_pkg::CSR_WINDOW_HIGH, 32'd5);
      pixel(32'd10);
      pixel(32'd11);
      write_csr(gwlr_pkg::CSR_WINDOW_HIGH, 32'd10);
      pixel(32'd9);
      pixel(32'd10);
      pixel(32'd11);

      for (int ph = 0; ph < 16; ph++) begin
         random_window();
         send_idle = idle_send[ph % 4];
         recv_stall = idle_recv[ph % 4];
         for (int n = 0; n < 64; n++) begin
            if ($urandom_range(99) < 15)
               send(gwlr_pkg::OP_WRITE, $urandom, 8'($urandom), 8'($urandom),
                    1'($urandom));
            else
               pixel(pick_sample(), $urandom_range(7) == 0);
         end
      end

      push <= 1'b0;
      send_idle = 0;
      recv_stall = 0;
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      $display("Checked %0d pixels and %0d table writes over 16 window settings", pixels_checked,
               writes_sent);
      $display("and four sender/receiver idling mixes.");
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
